// ===== rtl/ppig_pkg.sv =====
package ppig_pkg;

    localparam int ANGLE_W = 8;
    localparam int TERM_W  = 7;
    localparam int SUM_W   = 9;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic signed [TERM_W-1:0] cos_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COL_STEP_FIRST   = 3'd0,
        REG_COL_STEP_SECOND  = 3'd1,
        REG_ROW_STEP_FIRST   = 3'd2,
        REG_ROW_STEP_SECOND  = 3'd3,
        REG_FRAME_STEP_ONE   = 3'd4,
        REG_FRAME_STEP_TWO   = 3'd5,
        REG_FRAME_STEP_THREE = 3'd6,
        REG_FRAME_STEP_FOUR  = 3'd7
    } reg_idx_t;

    localparam angle_t STEP_RESET [NUM_REGS] = '{
        8'd3, 8'd4, 8'd1, 8'd5, 8'd2, 8'd5, 8'd3, 8'd1
    };

    localparam angle_t PHASE_COL_FIRST_RESET  = 8'd5;
    localparam angle_t PHASE_COL_SECOND_RESET = 8'd3;
    localparam angle_t PHASE_ROW_FIRST_RESET  = 8'd2;
    localparam angle_t PHASE_ROW_SECOND_RESET = 8'd4;

    localparam logic [5:0] QUARTER_COS [65] = '{
        6'd32, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31,
        6'd31, 6'd31, 6'd31, 6'd30, 6'd30, 6'd30, 6'd30, 6'd29,
        6'd29, 6'd29, 6'd28, 6'd28, 6'd28, 6'd27, 6'd27, 6'd27,
        6'd26, 6'd26, 6'd25, 6'd25, 6'd24, 6'd24, 6'd23, 6'd23,
        6'd22, 6'd22, 6'd21, 6'd20, 6'd20, 6'd19, 6'd19, 6'd18,
        6'd17, 6'd17, 6'd16, 6'd15, 6'd15, 6'd14, 6'd13, 6'd12,
        6'd12, 6'd11, 6'd10, 6'd10, 6'd9,  6'd8,  6'd7,  6'd7,
        6'd6,  6'd5,  6'd4,  6'd3,  6'd3,  6'd2,  6'd1,  6'd0,
        6'd0
    };

    localparam logic [SUM_W-1:0] SUM_MAX = 9'd255;

    // Signed cosine, -32..32, unfolded from the quarter wave.
    function automatic cos_t cos_rom(input angle_t n);
        logic [ANGLE_W-1:0] k;
        logic [6:0] idx;
        cos_t val;
        k = (n > 8'd128) ? 8'(9'd256 - {1'b0, n}) : n;
        if (k <= 8'd64)
        begin
            idx = k[6:0];
            val = cos_t'({1'b0, QUARTER_COS[idx]});
        end
        else
        begin
            idx = 7'(8'd128 - k);
            val = -cos_t'({1'b0, QUARTER_COS[idx]});
        end
        return val;
    endfunction

    // 32 + cos(p + 32 + cos(q)), 0..64
    function automatic logic [TERM_W-1:0] plasma_term(input angle_t p, input angle_t q);
        cos_t c;
        angle_t arg;
        logic signed [7:0] t;
        c = cos_rom(q);
        arg = p + 8'd32 + angle_t'({c[TERM_W-1], c});
        c = cos_rom(arg);
        t = 8'sd32 + {c[TERM_W-1], c};
        return t[TERM_W-1:0];
    endfunction

endpackage

// ===== rtl/plasma_palette_index_generator.sv =====
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata[0] row_done, s_tlast frame_done
// m_axis    out  m_tvalid/m_tready  m_tdata[7:0] color_index
// apb       in   psel/penable       8 step registers at 4*i
//
// One request per cycle unless the output stalls; from accept to result the angle
// registers capture the position, the ROM/sum path feeds the output register.
// Angle state advances at accept. Reset (rst_n, async) restores the steps,
// phases and angles and empties the pipe. A stalled output holds its value and
// the stage behind it fills before s_tready drops.
module plasma_palette_index_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] row_done, [7:1] zero
    input  logic        s_tlast,   // frame_done
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] color_index
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ppig_pkg::angle_t step_reg [ppig_pkg::NUM_REGS];

    ppig_pkg::angle_t phase_cf_reg, phase_cs_reg, phase_rf_reg, phase_rs_reg;
    ppig_pkg::angle_t angle_cf_reg, angle_cs_reg, angle_rf_reg, angle_rs_reg;
    ppig_pkg::angle_t phase_cf_next, phase_cs_next, phase_rf_next, phase_rs_next;
    ppig_pkg::angle_t angle_cf_next, angle_cs_next, angle_rf_next, angle_rs_next;

    ppig_pkg::angle_t s1_cf_reg, s1_cs_reg, s1_rf_reg, s1_rs_reg;
    logic             s1_valid_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;

    logic in_acc;
    logic advance;
    logic row_done;
    logic frame_done;
    logic [ppig_pkg::REG_IDX_W-1:0] widx;
    logic [ppig_pkg::SUM_W-1:0]     sum;

    assign pready   = 1'b1;
    assign widx     = paddr[4:2];
    assign prdata   = {24'b0, step_reg[widx]};

    assign row_done   = s_tdata[0];
    assign frame_done = s_tlast;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppig_pkg::NUM_REGS; i++)
            begin
                step_reg[i] <= ppig_pkg::STEP_RESET[i];
            end
        end
        else if (psel && penable && pwrite)
        begin
            step_reg[widx] <= pwdata[7:0];
        end
    end

    always_comb
    begin
        phase_cf_next = phase_cf_reg;
        phase_cs_next = phase_cs_reg;
        phase_rf_next = phase_rf_reg;
        phase_rs_next = phase_rs_reg;
        angle_cf_next = angle_cf_reg;
        angle_cs_next = angle_cs_reg;
        angle_rf_next = angle_rf_reg;
        angle_rs_next = angle_rs_reg;
        if (frame_done)
        begin
            phase_cf_next = phase_cf_reg + step_reg[ppig_pkg::REG_FRAME_STEP_ONE];
            phase_cs_next = phase_cs_reg + step_reg[ppig_pkg::REG_FRAME_STEP_TWO];
            phase_rf_next = phase_rf_reg + step_reg[ppig_pkg::REG_FRAME_STEP_THREE];
            phase_rs_next = phase_rs_reg + step_reg[ppig_pkg::REG_FRAME_STEP_FOUR];
            angle_cf_next = phase_cf_next;
            angle_cs_next = phase_cs_next;
            angle_rf_next = phase_rf_next;
            angle_rs_next = phase_rs_next;
        end
        else if (row_done)
        begin
            angle_rf_next = angle_rf_reg + step_reg[ppig_pkg::REG_ROW_STEP_FIRST];
            angle_rs_next = angle_rs_reg + step_reg[ppig_pkg::REG_ROW_STEP_SECOND];
            angle_cf_next = phase_cf_reg;
            angle_cs_next = phase_cs_reg;
        end
        else
        begin
            angle_cf_next = angle_cf_reg + step_reg[ppig_pkg::REG_COL_STEP_FIRST];
            angle_cs_next = angle_cs_reg + step_reg[ppig_pkg::REG_COL_STEP_SECOND];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_cf_reg <= ppig_pkg::PHASE_COL_FIRST_RESET;
            phase_cs_reg <= ppig_pkg::PHASE_COL_SECOND_RESET;
            phase_rf_reg <= ppig_pkg::PHASE_ROW_FIRST_RESET;
            phase_rs_reg <= ppig_pkg::PHASE_ROW_SECOND_RESET;
            angle_cf_reg <= ppig_pkg::PHASE_COL_FIRST_RESET;
            angle_cs_reg <= ppig_pkg::PHASE_COL_SECOND_RESET;
            angle_rf_reg <= ppig_pkg::PHASE_ROW_FIRST_RESET;
            angle_rs_reg <= ppig_pkg::PHASE_ROW_SECOND_RESET;
        end
        else if (in_acc)
        begin
            phase_cf_reg <= phase_cf_next;
            phase_cs_reg <= phase_cs_next;
            phase_rf_reg <= phase_rf_next;
            phase_rs_reg <= phase_rs_next;
            angle_cf_reg <= angle_cf_next;
            angle_cs_reg <= angle_cs_next;
            angle_rf_reg <= angle_rf_next;
            angle_rs_reg <= angle_rs_next;
        end
    end

    // input stage: angles of the accepted position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cf_reg <= angle_cf_reg;
            s1_cs_reg <= angle_cs_reg;
            s1_rf_reg <= angle_rf_reg;
            s1_rs_reg <= angle_rs_reg;
        end
    end

    always_comb
    begin
        sum = {2'b0, ppig_pkg::plasma_term(s1_rf_reg, s1_cf_reg)}
            + {2'b0, ppig_pkg::plasma_term(s1_rs_reg, s1_cs_reg)}
            + {2'b0, ppig_pkg::plasma_term(s1_cf_reg, s1_rf_reg)}
            + {2'b0, ppig_pkg::plasma_term(s1_cs_reg, s1_rs_reg)};
        out_data_next = (sum > ppig_pkg::SUM_MAX) ? 8'hff : sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== test/palette_index_checker.sv =====
`timescale 1ns / 100ps

module palette_index_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] row_done, [7:1] zero
    input  logic        s_tlast,   // frame_done
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] color_index
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);

    localparam int COS_QUARTER [65] = '{
        32, 31, 31, 31, 31, 31, 31, 31, 31, 31, 31, 30, 30, 30, 30, 29,
        29, 29, 28, 28, 28, 27, 27, 27, 26, 26, 25, 25, 24, 24, 23, 23,
        22, 22, 21, 20, 20, 19, 19, 18, 17, 17, 16, 15, 15, 14, 13, 12,
        12, 11, 10, 10,  9,  8,  7,  7,  6,  5,  4,  3,  3,  2,  1,  0,
        0
    };

    ppig_pkg::angle_t step_reg [ppig_pkg::NUM_REGS];
    ppig_pkg::angle_t col_phase_a, col_phase_b, row_phase_a, row_phase_b;
    ppig_pkg::angle_t col_angle_a, col_angle_b, row_angle_a, row_angle_b;
    logic [7:0]       expected_index [$];
    int               error_total;

    function automatic int cos_lookup(input ppig_pkg::angle_t n);
        int k;
        k = int'(n);
        if (k > 128)
            k = 256 - k;
        if (k <= 64)
            return COS_QUARTER[k];
        return -COS_QUARTER[128 - k];
    endfunction

    function automatic int wave_term(input ppig_pkg::angle_t p, input ppig_pkg::angle_t q);
        ppig_pkg::angle_t arg;
        arg = ppig_pkg::angle_t'(int'(p) + 32 + cos_lookup(q));
        return 32 + cos_lookup(arg);
    endfunction

    function automatic logic [7:0] plasma_index();
        int total;
        total = wave_term(row_angle_a, col_angle_a) + wave_term(row_angle_b, col_angle_b)
              + wave_term(col_angle_a, row_angle_a) + wave_term(col_angle_b, row_angle_b);
        if (total > 255)
            total = 255;
        return 8'(total);
    endfunction

    // frame end implies row end
    task automatic advance_raster(input logic row_end, input logic frame_end);
        if (frame_end)
        begin
            col_phase_a = col_phase_a + step_reg[ppig_pkg::REG_FRAME_STEP_ONE];
            col_phase_b = col_phase_b + step_reg[ppig_pkg::REG_FRAME_STEP_TWO];
            row_phase_a = row_phase_a + step_reg[ppig_pkg::REG_FRAME_STEP_THREE];
            row_phase_b = row_phase_b + step_reg[ppig_pkg::REG_FRAME_STEP_FOUR];
            row_angle_a = row_phase_a;
            row_angle_b = row_phase_b;
            col_angle_a = col_phase_a;
            col_angle_b = col_phase_b;
        end
        else if (row_end)
        begin
            row_angle_a = row_angle_a + step_reg[ppig_pkg::REG_ROW_STEP_FIRST];
            row_angle_b = row_angle_b + step_reg[ppig_pkg::REG_ROW_STEP_SECOND];
            col_angle_a = col_phase_a;
            col_angle_b = col_phase_b;
        end
        else
        begin
            col_angle_a = col_angle_a + step_reg[ppig_pkg::REG_COL_STEP_FIRST];
            col_angle_b = col_angle_b + step_reg[ppig_pkg::REG_COL_STEP_SECOND];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < ppig_pkg::NUM_REGS; i++)
                step_reg[i] = ppig_pkg::STEP_RESET[i];
            col_phase_a = ppig_pkg::PHASE_COL_FIRST_RESET;
            col_phase_b = ppig_pkg::PHASE_COL_SECOND_RESET;
            row_phase_a = ppig_pkg::PHASE_ROW_FIRST_RESET;
            row_phase_b = ppig_pkg::PHASE_ROW_SECOND_RESET;
            col_angle_a = ppig_pkg::PHASE_COL_FIRST_RESET;
            col_angle_b = ppig_pkg::PHASE_COL_SECOND_RESET;
            row_angle_a = ppig_pkg::PHASE_ROW_FIRST_RESET;
            row_angle_b = ppig_pkg::PHASE_ROW_SECOND_RESET;
            expected_index.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_index.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%0t: color index %0d with no request pending", $realtime,
                                 m_tdata);
                end
                else
                begin
                    want = expected_index.pop_front();
                    if (m_tdata !== want)
                    begin
                        error_total++;
                        if (error_total <= 10)
                            $display("%0t: color index expected %0d, got %0d", $realtime,
                                     want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_index.push_back(plasma_index());
                advance_raster(s_tdata[0], s_tlast);
            end
            if (psel && penable && pwrite && pready)
                step_reg[paddr[4:2]] = pwdata[7:0];
            mismatches <= error_total;
            pending <= expected_index.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 200;

    // {frame_done, row_done}
    localparam logic [1:0] DIRECTED [24] = '{
        2'b00, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00, 2'b00, 2'b01, 2'b10, 2'b00, 2'b01, 2'b00,
        2'b00, 2'b01, 2'b00, 2'b11, 2'b00,
        2'b00, 2'b00, 2'b01, 2'b10, 2'b00, 2'b11, 2'b00
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] row_done, [7:1] zero
    logic        s_tlast;   // frame_done
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] color_index
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int          quiet_cycles = 0;
    bit          hold_req = 1'b0;
    bit          no_idle = 1'b0;
    int          col_pos = 0;
    int          row_pos = 0;
    int          row_len = 4;
    int          frame_rows = 3;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    plasma_palette_index_generator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    palette_index_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic ppig_pkg::angle_t pick_step();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return ppig_pkg::angle_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_step(input ppig_pkg::reg_idx_t idx, input ppig_pkg::angle_t value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_steps(input ppig_pkg::angle_t value);
        for (int r = 0; r < ppig_pkg::NUM_REGS; r++)
            write_step(ppig_pkg::reg_idx_t'(r), value);
    endtask

    task automatic send_item(input logic row_end, input logic frame_end);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, row_end};
        s_tlast <= frame_end;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // well-formed raster most of the time, stray flags otherwise
    task automatic send_random_item();
        logic row_end, frame_end;
        row_end = 1'b0;
        frame_end = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            row_end = 1'($urandom_range(0, 1));
            frame_end = ($urandom_range(0, 5) == 0);
        end
        else
        begin
            col_pos++;
            if (col_pos >= row_len)
            begin
                row_end = 1'b1;
                col_pos = 0;
                row_pos++;
                if (row_pos >= frame_rows)
                begin
                    frame_end = 1'b1;
                    row_pos = 0;
                    row_len = $urandom_range(1, 12);
                    frame_rows = $urandom_range(1, 6);
                end
            end
        end
        send_item(row_end, frame_end);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 5'd0;
        pwdata = 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first frame end moves every angle to the 209/212 fixed point: sum of 256
        write_step(ppig_pkg::REG_COL_STEP_FIRST, 8'd255);
        write_step(ppig_pkg::REG_COL_STEP_SECOND, 8'd0);
        write_step(ppig_pkg::REG_ROW_STEP_FIRST, 8'd0);
        write_step(ppig_pkg::REG_ROW_STEP_SECOND, 8'd255);
        write_step(ppig_pkg::REG_FRAME_STEP_ONE, 8'd207);
        write_step(ppig_pkg::REG_FRAME_STEP_TWO, 8'd209);
        write_step(ppig_pkg::REG_FRAME_STEP_THREE, 8'd207);
        write_step(ppig_pkg::REG_FRAME_STEP_FOUR, 8'd205);
        for (int i = 0; i < 24; i++)
        begin
            if (i == 12)
            begin
                quiesce();
                write_all_steps(8'd0);
            end
            if (i == 17)
            begin
                quiesce();
                write_all_steps(8'd255);
            end
            send_item(DIRECTED[i][0], DIRECTED[i][1]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            quiesce();
            no_idle = (p == 2);
            for (int r = 0; r < ppig_pkg::NUM_REGS; r++)
                write_step(ppig_pkg::reg_idx_t'(r), pick_step());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == 40)
                    hold_req = 1'b1;
                if (p == 3 && i == 100)
                    quiesce();
                send_random_item();
            end
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int run_left;
        m_tready = 1'b0;
        run_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                run_left = 0;
            end
            else if (no_idle)
                m_tready <= 1'b1;
            else if (run_left > 0)
                run_left--;
            else if ($urandom_range(0, 1) == 1)
            begin
                m_tready <= 1'b1;
                run_left = $urandom_range(0, 7);
            end
            else
            begin
                m_tready <= 1'b0;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(0, 2);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
